/* hdl/kci_pkg.sv */
`default_nettype none

package kci_pkg;

   // number formats
   localparam int VALUE_WIDTH = 32;
   localparam int T_FRAC_BITS = 16;
   localparam int T_WIDTH     = T_FRAC_BITS + 1;
   localparam int OP_WIDTH    = 2;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_LINEAR  = 2'd0,
      OP_STEP    = 2'd1,
      OP_HERMITE = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0]           opcode;
      logic [T_WIDTH-1:0]            t_frac;
      logic signed [VALUE_WIDTH-1:0] start_value;
      logic signed [VALUE_WIDTH-1:0] start_tangent;
      logic signed [VALUE_WIDTH-1:0] end_value;
      logic signed [VALUE_WIDTH-1:0] end_tangent;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] interp_value;
      logic                          saturated;
   } rsp_type;

endpackage

`default_nettype wire

/* hdl/keyframe_component_interpolator.sv */
`default_nettype none

// channel  direction  ports                          payload
// req      in         req_valid req_stall req_data   opcode, t, two values, two tangents
// rsp      out        rsp_valid rsp_stall rsp_data   interpolated value, saturated flag
//
// seven register stages: t squared, t cubed, basis weights, four products,
// pair sums, rounded total, clamp and output register
// one transaction accepted per cycle while req_stall is low, result on rsp from the output register
// reset (synchronous) clears only the stage valid bits
// each stage holds while the one after it is full and cannot move, so empty
// stages keep filling behind a stalled result; nothing is lost or repeated

module keyframe_component_interpolator
   import kci_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int STAGES = 7;
   localparam int VW     = VALUE_WIDTH;
   localparam int TB     = T_FRAC_BITS;
   localparam int TW     = T_WIDTH;
   localparam int SQW    = 2 * TW;          // t times t
   localparam int WW     = TW + 1;          // signed weight
   localparam int XW     = TW + 3;          // weight arithmetic headroom
   localparam int PW     = VW + WW;         // one product
   localparam int HW     = PW + 1;          // pair sum
   localparam int SW     = PW + 2;          // full sum
   localparam int RW     = SW - TB;         // rounded, before clamp

   localparam logic [TW-1:0]         ONE_T     = TW'(1) << TB;
   localparam logic [SQW-1:0]        HALF_SQ   = SQW'(1) << (TB - 1);
   localparam logic signed [SW-1:0]  HALF_SUM  = SW'(1) << (TB - 1);
   localparam logic signed [RW-1:0]  RES_MAX   = {{(RW-VW+1){1'b0}}, {(VW-1){1'b1}}};
   localparam logic signed [RW-1:0]  RES_MIN   = {{(RW-VW+1){1'b1}}, {(VW-1){1'b0}}};
   localparam logic signed [VW-1:0]  VAL_MAX   = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0]  VAL_MIN   = {1'b1, {(VW-1){1'b0}}};

   // handshake: a stage takes new data when it is empty or drains this cycle
   logic [STAGES-1:0] vld_ff, vld_in, rdy;

   always_comb begin
      rdy[STAGES-1] = !vld_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = req_valid;
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[STAGES-1];

   // stage 0: clamp t to one, square it
   req_type          s0_item_ff, s0_item_in;
   logic [TW-1:0]    s0_t2_ff, s0_t2_in;
   logic [TW-1:0]    t_clamped;
   logic [SQW-1:0]   t_sq;

   always_comb begin
      t_clamped = (req_data.t_frac > ONE_T) ? ONE_T : req_data.t_frac;
      t_sq      = SQW'(t_clamped) * SQW'(t_clamped);
      s0_t2_in  = TW'((t_sq + HALF_SQ) >> TB);
      s0_item_in        = req_data;
      s0_item_in.t_frac = t_clamped;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s0_item_ff <= s0_item_in;
         s0_t2_ff   <= s0_t2_in;
      end
   end

   // stage 1: t cubed from rounded t squared
   req_type        s1_item_ff;
   logic [TW-1:0]  s1_t2_ff, s1_t3_ff, s1_t3_in;
   logic [SQW-1:0] t_cu;

   always_comb begin
      t_cu     = SQW'(s0_t2_ff) * SQW'(s0_item_ff.t_frac);
      s1_t3_in = TW'((t_cu + HALF_SQ) >> TB);
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_item_ff <= s0_item_ff;
         s1_t2_ff   <= s0_t2_ff;
         s1_t3_ff   <= s1_t3_in;
      end
   end

   // stage 2: basis weights per opcode
   req_type                s2_item_ff;
   logic signed [WW-1:0]   s2_w_ff [4];
   logic signed [WW-1:0]   s2_w_in [4];
   logic signed [XW-1:0]   tx, t2x, t3x, onex;

   always_comb begin
      tx   = $signed({{(XW-TW){1'b0}}, s1_item_ff.t_frac});
      t2x  = $signed({{(XW-TW){1'b0}}, s1_t2_ff});
      t3x  = $signed({{(XW-TW){1'b0}}, s1_t3_ff});
      onex = $signed({{(XW-TW){1'b0}}, ONE_T});
      for (int k = 0; k < 4; k++) begin
         s2_w_in[k] = '0;
      end
      if (s1_item_ff.opcode == OP_HERMITE) begin
         s2_w_in[0] = WW'((t3x <<< 1) - (t2x <<< 1) - t2x + onex);
         s2_w_in[1] = WW'(t3x - (t2x <<< 1) + tx);
         s2_w_in[2] = WW'((t2x <<< 1) + t2x - (t3x <<< 1));
         s2_w_in[3] = WW'(t3x - t2x);
      end else begin
         // linear mix; the step case ignores the weights
         s2_w_in[0] = WW'(onex - tx);
         s2_w_in[2] = WW'(tx);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s2_item_ff <= s1_item_ff;
         s2_w_ff    <= s2_w_in;
      end
   end

   // stage 3: four signed products
   logic [OP_WIDTH-1:0]    s3_op_ff;
   logic signed [VW-1:0]   s3_v0_ff;
   logic signed [PW-1:0]   s3_p_ff [4];
   logic signed [PW-1:0]   s3_p_in [4];

   always_comb begin
      s3_p_in[0] = PW'($signed(s2_item_ff.start_value))   * PW'(s2_w_ff[0]);
      s3_p_in[1] = PW'($signed(s2_item_ff.start_tangent)) * PW'(s2_w_ff[1]);
      s3_p_in[2] = PW'($signed(s2_item_ff.end_value))     * PW'(s2_w_ff[2]);
      s3_p_in[3] = PW'($signed(s2_item_ff.end_tangent))   * PW'(s2_w_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s3_op_ff <= s2_item_ff.opcode;
         s3_v0_ff <= s2_item_ff.start_value;
         s3_p_ff  <= s3_p_in;
      end
   end

   // stage 4: pair sums
   logic [OP_WIDTH-1:0]  s4_op_ff;
   logic signed [VW-1:0] s4_v0_ff;
   logic signed [HW-1:0] s4_a_ff, s4_b_ff;

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s4_op_ff <= s3_op_ff;
         s4_v0_ff <= s3_v0_ff;
         s4_a_ff  <= HW'(s3_p_ff[0]) + HW'(s3_p_ff[1]);
         s4_b_ff  <= HW'(s3_p_ff[2]) + HW'(s3_p_ff[3]);
      end
   end

   // stage 5: total, round half up, drop the fraction
   logic [OP_WIDTH-1:0]  s5_op_ff;
   logic signed [VW-1:0] s5_v0_ff;
   logic signed [RW-1:0] s5_res_ff;
   logic signed [SW-1:0] sum_all;

   always_comb begin
      sum_all = SW'(s4_a_ff) + SW'(s4_b_ff) + HALF_SUM;
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s5_op_ff  <= s4_op_ff;
         s5_v0_ff  <= s4_v0_ff;
         s5_res_ff <= RW'(sum_all >>> TB);
      end
   end

   // stage 6: clamp, or pass the first value for step or an unused opcode
   logic [OP_WIDTH-1:0] s6_op_ff;
   rsp_type             s6_rsp_ff, s6_rsp_in;

   always_comb begin
      if (s5_op_ff != OP_LINEAR && s5_op_ff != OP_HERMITE) begin
         s6_rsp_in.interp_value = s5_v0_ff;
         s6_rsp_in.saturated    = 1'b0;
      end else if (s5_res_ff > RES_MAX) begin
         s6_rsp_in.interp_value = VAL_MAX;
         s6_rsp_in.saturated    = 1'b1;
      end else if (s5_res_ff < RES_MIN) begin
         s6_rsp_in.interp_value = VAL_MIN;
         s6_rsp_in.saturated    = 1'b1;
      end else begin
         s6_rsp_in.interp_value = VW'(s5_res_ff);
         s6_rsp_in.saturated    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         s6_op_ff  <= s5_op_ff;
         s6_rsp_ff <= s6_rsp_in;
      end
   end

   assign rsp_data = s6_rsp_ff;

   // a full pipe behind a stalled result must push back on the input
   assert property (@(posedge clock) disable iff (reset)
      (&vld_ff) && rsp_stall |-> req_stall)
      else $error("full pipeline not stalling input");

   // only the spline can leave the value range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && s6_op_ff != OP_HERMITE |-> !rsp_data.saturated)
      else $error("saturation outside spline opcode");

   // a clamped result sits on a range limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.interp_value == VAL_MAX || rsp_data.interp_value == VAL_MIN)
      else $error("saturated result not at range limit");

   // t never exceeds one past the first stage
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> s0_item_ff.t_frac <= ONE_T && s0_t2_ff <= ONE_T)
      else $error("t above one after clamp");

endmodule

`default_nettype wire
